// ----- design/rau_pkg.sv -----
// ----------------------------------------------------------------------------
// Rotary angle unit counter package
// Constants, arithmetic unit codes and the command/status types shared by
// the core and its serial multiply/divide unit.
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int ANGLE_W      = 13;
   localparam int UNITS_W      = 13;
   localparam int MASK_W       = 2;
   localparam int COUNT_W      = 32;
   localparam int UNIT_OUT_W   = 16;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 13;

   localparam int TURN_SPAN     = 360 * 16;
   localparam int HALF_SCALE    = TURN_SPAN / 2;
   localparam int DEFAULT_UNITS = 80;

   // Product of a counter magnitude and the units per turn.
   localparam int PROD_W    = COUNT_W + UNITS_W;
   // Dividend padded to an even width for two quotient bits per cycle.
   localparam int DIV_W     = PROD_W + (PROD_W % 2);
   localparam int MUL_STEPS = UNITS_W;
   localparam int DIV_STEPS = DIV_W / 2;
   localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [CSR_IDX_W-1:0] CSR_UNITS_PER_TURN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_REVERSE_MASK   = 1'b1;

   localparam logic ARITH_OP_MUL = 1'b0;
   localparam logic ARITH_OP_DIV = 1'b1;

   typedef struct packed {
      logic                  start;
      logic                  op;
      logic [COUNT_W-1:0]    mcand;
      logic [UNITS_W-1:0]    mplier;
      logic [PROD_W-1:0]     dividend;
   } arith_cmd_type;

   typedef struct packed {
      logic                  done;
      logic [PROD_W-1:0]     product;
      logic [UNIT_OUT_W-1:0] quotient;
   } arith_status_type;

endpackage

// ----- design/rau_serial_arith.sv -----
// ----------------------------------------------------------------------------
// Serial multiply / divide unit
// Shift-add multiplier taking one multiplier bit per cycle, and a restoring
// divider by the full-turn constant retiring two quotient bits per cycle.
// ----------------------------------------------------------------------------
module rau_serial_arith (
   input  logic                      clock,
   input  logic                      reset,
   input  rau_pkg::arith_cmd_type    cmd,
   output rau_pkg::arith_status_type status
);
   import rau_pkg::*;

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic                    op_ff, op_in;
   logic [STEP_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COUNT_W-1:0]      mcand_ff, mcand_in;
   logic [UNITS_W-1:0]      mplier_ff, mplier_in;
   logic [PROD_W-1:0]       acc_ff, acc_in;
   logic [DIV_W-1:0]        div_ff, div_in;
   logic [ANGLE_W-1:0]      rem_ff, rem_in;
   logic [UNIT_OUT_W-1:0]   quo_ff, quo_in;

   logic [ANGLE_W:0]        t0, t1;
   logic                    ge0, ge1;
   logic [ANGLE_W-1:0]      r0, r1;

   // Two restoring steps; the remainder always stays below the divisor.
   always_comb begin
      t0  = {rem_ff, div_ff[DIV_W-1]};
      ge0 = t0 >= (ANGLE_W+1)'(TURN_SPAN);
      r0  = ge0 ? ANGLE_W'(t0 - (ANGLE_W+1)'(TURN_SPAN)) : t0[ANGLE_W-1:0];
      t1  = {r0, div_ff[DIV_W-2]};
      ge1 = t1 >= (ANGLE_W+1)'(TURN_SPAN);
      r1  = ge1 ? ANGLE_W'(t1 - (ANGLE_W+1)'(TURN_SPAN)) : t1[ANGLE_W-1:0];
   end

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      op_in     = op_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      div_in    = div_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      if (busy_ff) begin
         if (op_ff == ARITH_OP_MUL) begin
            acc_in    = {acc_ff[PROD_W-2:0], 1'b0}
                        + (mplier_ff[UNITS_W-1] ? PROD_W'(mcand_ff) : '0);
            mplier_in = {mplier_ff[UNITS_W-2:0], 1'b0};
         end else begin
            rem_in = r1;
            quo_in = {quo_ff[UNIT_OUT_W-3:0], ge0, ge1};
            div_in = {div_ff[DIV_W-3:0], 2'b00};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (cmd.start) begin
         busy_in = 1'b1;
         op_in   = cmd.op;
         if (cmd.op == ARITH_OP_MUL) begin
            cnt_in    = STEP_CNT_W'(MUL_STEPS);
            mcand_in  = cmd.mcand;
            mplier_in = cmd.mplier;
            acc_in    = '0;
         end else begin
            cnt_in = STEP_CNT_W'(DIV_STEPS);
            div_in = DIV_W'(cmd.dividend);
            rem_in = '0;
            quo_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      cnt_ff    <= cnt_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
      div_ff    <= div_in;
      rem_ff    <= rem_in;
      quo_ff    <= quo_in;
   end

   assign status.done     = done_ff;
   assign status.product  = acc_ff;
   assign status.quotient = quo_ff;

endmodule

// ----- design/rotary_angle_unit_counter_core.sv -----
// An accepted request steps through S_DELTA, S_THR, S_MUL and S_DIV to S_OUT;
// a knob index outside the knob count goes straight to S_OUT.
// A request is taken only in S_IDLE, after the last response is registered;
// two shift-add multiplies and a radix-4 divide by 5760 share the serial unit.
// Reset (synchronous): knob angles and counters cleared, units per turn 80,
// reverse mask 0, no response pending.
// ----------------------------------------------------------------------------
// Rotary angle unit counter core
// Mirrors, unwraps and thresholds absolute knob angles, keeps a saturating
// per-knob angle counter and scales it to output units per turn.
// ----------------------------------------------------------------------------
module rotary_angle_unit_counter_core #(
   parameter int NUM_KNOBS = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_knob_index,
   input  logic [rau_pkg::ANGLE_W-1:0]         req_raw_angle,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [rau_pkg::ANGLE_W-1:0]         rsp_corrected_angle,
   output logic [rau_pkg::UNIT_OUT_W-1:0]      rsp_unit_count,
   input  logic                                csr_wr_en,
   input  logic [rau_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [rau_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import rau_pkg::*;

   localparam int KIDX_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DELTA = 3'd1;
   localparam logic [2:0] S_THR   = 3'd2;
   localparam logic [2:0] S_MUL   = 3'd3;
   localparam logic [2:0] S_DIV   = 3'd4;
   localparam logic [2:0] S_OUT   = 3'd5;

   logic [2:0]              state_ff, state_in;
   logic [UNITS_W-1:0]      units_ff;
   logic [MASK_W-1:0]       mask_ff;
   logic [ANGLE_W-1:0]      last_angle_ff [NUM_KNOBS];
   logic [COUNT_W-1:0]      turn_counter_ff [NUM_KNOBS];
   logic                    knob_wr;
   logic [COUNT_W-1:0]      turn_counter_in;

   logic [KIDX_W-1:0]       knob_ff, knob_in;
   logic                    ok_ff, ok_in;
   logic [ANGLE_W-1:0]      angle_ff, angle_in;
   logic [ANGLE_W-1:0]      delta_ff, delta_in;
   logic                    sign_ff, sign_in;
   logic [UNIT_OUT_W-1:0]   result_ff, result_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ANGLE_W-1:0]      rsp_angle_ff, rsp_angle_in;
   logic [UNIT_OUT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [ANGLE_W-1:0]      folded, mirrored;
   logic [UNITS_W-1:0]      units_eff;
   logic [ANGLE_W:0]        diff, wrapped;
   logic [ANGLE_W-1:0]      dmag;
   logic [COUNT_W:0]        sum;
   logic [COUNT_W-1:0]      old_count, sat_count, new_count, count_mag;
   logic                    move;

   arith_cmd_type           cmd;
   arith_status_type        st;

   rau_serial_arith u_arith (
      .clock  (clock),
      .reset  (reset),
      .cmd    (cmd),
      .status (st)
   );

   assign units_eff = (units_ff == '0) ? UNITS_W'(DEFAULT_UNITS) : units_ff;

   // Input angle: fold the out-of-range codes, then mirror if requested.
   always_comb begin
      folded   = (req_raw_angle >= ANGLE_W'(TURN_SPAN))
                 ? req_raw_angle - ANGLE_W'(TURN_SPAN) : req_raw_angle;
      mirrored = mask_ff[req_knob_index] ? ANGLE_W'(TURN_SPAN) - folded : folded;
   end

   // Difference to the last accepted angle, unwrapped into half a turn.
   always_comb begin
      diff = {1'b0, angle_ff} - {1'b0, last_angle_ff[knob_ff]};
      if ($signed(diff) > $signed((ANGLE_W+1)'(HALF_SCALE))) begin
         wrapped = diff - (ANGLE_W+1)'(TURN_SPAN);
      end else if ($signed(diff) < -$signed((ANGLE_W+1)'(HALF_SCALE))) begin
         wrapped = diff + (ANGLE_W+1)'(TURN_SPAN);
      end else begin
         wrapped = diff;
      end
      dmag = wrapped[ANGLE_W] ? ANGLE_W'(-wrapped) : wrapped[ANGLE_W-1:0];
   end

   // The step is 5760 / units; |delta| reaches it exactly when
   // (|delta| + 1) * units exceeds a full turn.
   always_comb begin
      old_count = turn_counter_ff[knob_ff];
      sum       = {old_count[COUNT_W-1], old_count}
                  + {{(COUNT_W+1-ANGLE_W){delta_ff[ANGLE_W-1]}}, delta_ff};
      case (sum[COUNT_W:COUNT_W-1])
         2'b01:   sat_count = {1'b0, {(COUNT_W-1){1'b1}}};
         2'b10:   sat_count = {1'b1, {(COUNT_W-1){1'b0}}};
         default: sat_count = sum[COUNT_W-1:0];
      endcase
      move      = st.product > PROD_W'(TURN_SPAN);
      new_count = move ? sat_count : old_count;
      count_mag = new_count[COUNT_W-1] ? -new_count : new_count;
   end

   always_comb begin
      state_in        = state_ff;
      knob_in         = knob_ff;
      ok_in           = ok_ff;
      angle_in        = angle_ff;
      delta_in        = delta_ff;
      sign_in         = sign_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_valid_ff & ~rsp_ready;
      rsp_angle_in    = rsp_angle_ff;
      rsp_count_in    = rsp_count_ff;
      knob_wr         = 1'b0;
      turn_counter_in = new_count;
      cmd             = '0;
      cmd.mplier      = units_eff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               knob_in  = KIDX_W'(req_knob_index);
               ok_in    = 32'(req_knob_index) < 32'(NUM_KNOBS);
               angle_in = mirrored;
               state_in = (32'(req_knob_index) < 32'(NUM_KNOBS)) ? S_DELTA : S_OUT;
            end
         end
         S_DELTA: begin
            delta_in  = wrapped[ANGLE_W-1:0];
            cmd.start = 1'b1;
            cmd.op    = ARITH_OP_MUL;
            cmd.mcand = COUNT_W'(dmag) + COUNT_W'(1);
            state_in  = S_THR;
         end
         S_THR: begin
            if (st.done) begin
               knob_wr   = move;
               sign_in   = new_count[COUNT_W-1];
               cmd.start = 1'b1;
               cmd.op    = ARITH_OP_MUL;
               cmd.mcand = count_mag;
               state_in  = S_MUL;
            end
         end
         S_MUL: begin
            if (st.done) begin
               cmd.start    = 1'b1;
               cmd.op       = ARITH_OP_DIV;
               cmd.dividend = st.product;
               state_in     = S_DIV;
            end
         end
         S_DIV: begin
            if (st.done) begin
               result_in = sign_ff ? -st.quotient : st.quotient;
               state_in  = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_angle_in = ok_ff ? angle_ff : '0;
               rsp_count_in = ok_ff ? result_ff : '0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         units_ff     <= UNITS_W'(DEFAULT_UNITS);
         mask_ff      <= '0;
         for (int k = 0; k < NUM_KNOBS; k++) begin
            last_angle_ff[k]   <= '0;
            turn_counter_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_UNITS_PER_TURN: units_ff <= csr_wdata[UNITS_W-1:0];
               CSR_REVERSE_MASK:   mask_ff  <= csr_wdata[MASK_W-1:0];
               default:            ;
            endcase
         end
         if (knob_wr) begin
            last_angle_ff[knob_ff]   <= angle_ff;
            turn_counter_ff[knob_ff] <= turn_counter_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      knob_ff      <= knob_in;
      ok_ff        <= ok_in;
      angle_ff     <= angle_in;
      delta_ff     <= delta_in;
      sign_ff      <= sign_in;
      result_ff    <= result_in;
      rsp_angle_ff <= rsp_angle_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_corrected_angle = rsp_angle_ff;
   assign rsp_unit_count      = rsp_count_ff;

endmodule

// ----- dv/rotary_angle_unit_counter_core_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Rotary angle unit counter core testbench
// Streams knob angle samples through the core under bursty request traffic
// and a stalling response side. A per-knob unwrap and scale predictor runs
// beside the core, and every response beat is checked in order against it.
// ----------------------------------------------------------------------------
module rotary_angle_unit_counter_core_tb;
   import rau_pkg::*;

   localparam int KNOB_COUNT = 2;

   typedef struct packed {
      logic                 knob_index;
      logic [ANGLE_W-1:0]   raw_angle;
   } knob_sample_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]    corrected_angle;
      logic [UNIT_OUT_W-1:0] unit_count;
   } knob_reading_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_knob_index = 1'b0;
   logic [ANGLE_W-1:0]    req_raw_angle = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ANGLE_W-1:0]    rsp_corrected_angle;
   logic [UNIT_OUT_W-1:0] rsp_unit_count;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   knob_sample_type  pending_samples_q[$];
   knob_reading_type expected_readings_q[$];

   // Predictor copy of the configuration and the per-knob state.
   logic [UNITS_W-1:0] units_cfg;
   logic [MASK_W-1:0]  mirror_cfg;
   int                 knob_last_angle[KNOB_COUNT];
   int                 knob_turns[KNOB_COUNT];

   // Stimulus-side angle trackers, used to build steady rotations.
   int spin_pos[KNOB_COUNT];
   int spin_dir[KNOB_COUNT];

   logic req_beat_taken = 1'b0;
   int   mismatch_count = 0;
   int   burst_left = 1;
   int   gap_left = 0;
   int   rsp_mode = 0;
   int   rsp_left = 0;

   rotary_angle_unit_counter_core #(
      .NUM_KNOBS(KNOB_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_knob_index(req_knob_index),
      .req_raw_angle(req_raw_angle),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_corrected_angle(rsp_corrected_angle),
      .rsp_unit_count(rsp_unit_count),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #1 clock = ~clock;

   // Mirror, unwrap and threshold one sample, then scale the knob's counter.
   function automatic knob_reading_type advance_knob(input logic knob,
                                                     input logic [ANGLE_W-1:0] raw);
      int               angle;
      int               delta;
      int               units;
      int               step;
      longint           sum;
      longint           scaled;
      knob_reading_type reading;
      angle = int'(raw);
      if (angle >= TURN_SPAN)
         angle -= TURN_SPAN;
      if (mirror_cfg[knob])
         angle = TURN_SPAN - angle;
      delta = angle - knob_last_angle[knob];
      if (delta > HALF_SCALE)
         delta -= TURN_SPAN;
      else if (delta < -HALF_SCALE)
         delta += TURN_SPAN;
      units = (units_cfg == 0) ? DEFAULT_UNITS : int'(units_cfg);
      step = TURN_SPAN / units;
      if (delta <= -step || delta >= step) begin
         knob_last_angle[knob] = angle;
         sum = longint'(knob_turns[knob]) + longint'(delta);
         if (sum > longint'(32'sh7fffffff))
            sum = longint'(32'sh7fffffff);
         else if (sum < -longint'(32'sh7fffffff) - 1)
            sum = -longint'(32'sh7fffffff) - 1;
         knob_turns[knob] = int'(sum);
      end
      // Signed division truncates toward zero.
      scaled = (longint'(knob_turns[knob]) * longint'(units)) / longint'(TURN_SPAN);
      reading.corrected_angle = ANGLE_W'(angle);
      reading.unit_count = UNIT_OUT_W'(scaled);
      return reading;
   endfunction

   task automatic queue_sample(input logic knob, input int raw);
      knob_sample_type sample;
      sample.knob_index = knob;
      sample.raw_angle = ANGLE_W'(raw);
      pending_samples_q.push_back(sample);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_UNITS_PER_TURN)
         units_cfg = UNITS_W'(value);
      else
         mirror_cfg = MASK_W'(value);
   endtask

   // Sampled just after a rising edge, so every beat of that edge is settled.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
         #0.5;
      end while (pending_samples_q.size() != 0 || req_valid ||
                 expected_readings_q.size() != 0);
   endtask

   task automatic reconfigure(input int units, input int mask);
      wait_until_drained();
      write_csr(CSR_UNITS_PER_TURN, CSR_DATA_W'(units));
      write_csr(CSR_REVERSE_MASK, CSR_DATA_W'(mask));
      @(posedge clock);
      #0.5;
   endtask

   // Mostly steady rotations in large strides, so the counters travel far,
   // mixed with jitter near the threshold and arbitrary or out-of-range angles.
   task automatic queue_random_samples(input int count);
      int   pick;
      int   move;
      int   raw;
      logic knob;
      for (int i = 0; i < count; i++) begin
         knob = 1'($urandom_range(0, 1));
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            move = $urandom_range(0, HALF_SCALE);
            if ($urandom_range(0, 15) == 0)
               spin_dir[knob] = -spin_dir[knob];
            spin_pos[knob] = (spin_pos[knob] + TURN_SPAN + spin_dir[knob] * move)
                             % TURN_SPAN;
            raw = spin_pos[knob];
         end else if (pick < 80) begin
            move = $urandom_range(0, 300);
            spin_pos[knob] = (spin_pos[knob] + TURN_SPAN + move - 150) % TURN_SPAN;
            raw = spin_pos[knob];
         end else if (pick < 92) begin
            raw = $urandom_range(0, TURN_SPAN - 1);
         end else begin
            raw = $urandom_range(TURN_SPAN, (1 << ANGLE_W) - 1);
         end
         queue_sample(knob, raw);
      end
   endtask

   // Request driver: bursts of beats separated by random gaps.
   always @(negedge clock) begin : req_driver
      knob_sample_type next_sample;
      logic            drive;
      if (!reset && (!req_valid || req_beat_taken)) begin
         drive = 1'b0;
         if (gap_left != 0) begin
            gap_left--;
         end else if (pending_samples_q.size() != 0) begin
            next_sample = pending_samples_q.pop_front();
            req_knob_index <= next_sample.knob_index;
            req_raw_angle <= next_sample.raw_angle;
            drive = 1'b1;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 120);
            end else begin
               burst_left--;
            end
         end
         req_valid <= drive;
      end
   end

   // Response side: solid-ready stretches, flickering stretches and stalls.
   always @(negedge clock) begin : rsp_stall
      if (rsp_left == 0) begin
         rsp_mode = $urandom_range(0, 3);
         rsp_left = $urandom_range(1, 80);
      end
      rsp_left--;
      case (rsp_mode)
         0, 1: rsp_ready <= 1'b1;
         2: rsp_ready <= 1'($urandom_range(0, 1));
         default: rsp_ready <= 1'b0;
      endcase
   end

   always @(posedge clock) begin : beat_monitor
      knob_reading_type wanted;
      req_beat_taken = !reset && req_valid && req_ready;
      if (req_beat_taken)
         expected_readings_q.push_back(advance_knob(req_knob_index, req_raw_angle));
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response beat: angle %0d count %0d",
                        rsp_corrected_angle, rsp_unit_count);
         end else begin
            wanted = expected_readings_q.pop_front();
            if (rsp_corrected_angle !== wanted.corrected_angle ||
                rsp_unit_count !== wanted.unit_count) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"response mismatch: expected angle %0d count %0d, ",
                            "got angle %0d count %0d"},
                           wanted.corrected_angle, wanted.unit_count,
                           rsp_corrected_angle, rsp_unit_count);
            end
         end
      end
   end

   initial begin : run_limit
      #3_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin : stimulus
      units_cfg = UNITS_W'(DEFAULT_UNITS);
      mirror_cfg = '0;
      for (int k = 0; k < KNOB_COUNT; k++) begin
         knob_last_angle[k] = 0;
         knob_turns[k] = 0;
         spin_pos[k] = 0;
         spin_dir[k] = 1;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      #0.5;

      // Reset settings: below, at and across the threshold, the half-turn
      // boundary both ways, and raw angles beyond a full turn.
      queue_sample(1'b0, 0);
      queue_sample(1'b0, 71);
      queue_sample(1'b0, 72);
      queue_sample(1'b0, 5759);
      queue_sample(1'b0, 5700);
      queue_sample(1'b0, 2879);
      queue_sample(1'b1, 2880);
      queue_sample(1'b1, 0);
      queue_sample(1'b1, 5760);
      queue_sample(1'b1, 8191);
      queue_sample(1'b1, 6000);
      queue_sample(1'b1, 4096);

      // Zero units per turn falls back to the default; both knobs mirrored.
      reconfigure(0, 3);
      queue_sample(1'b0, 0);
      queue_sample(1'b0, 5760);
      queue_sample(1'b1, 5759);
      queue_sample(1'b1, 1);

      // Units above a full turn give a zero step, so a repeat is accepted.
      reconfigure(8191, 1);
      queue_sample(1'b0, 1000);
      queue_sample(1'b0, 1000);
      queue_sample(1'b1, 3000);

      reconfigure(5760, 2);
      queue_sample(1'b1, 100);
      queue_sample(1'b1, 101);

      // One unit per turn: the step is a full turn and nothing ever moves.
      reconfigure(1, 0);
      queue_sample(1'b0, 2880);
      queue_sample(1'b1, 0);

      for (int p = 0; p < 8; p++) begin
         case (p)
            0: reconfigure(5760, 3);
            1: reconfigure(8191, 0);
            2: reconfigure(1, 1);
            3: reconfigure(0, 2);
            4: reconfigure(DEFAULT_UNITS, 0);
            5: reconfigure($urandom_range(2, 200), $urandom_range(0, 3));
            6: reconfigure($urandom_range(TURN_SPAN + 1, 8191), $urandom_range(0, 3));
            default: reconfigure($urandom_range(0, 8191), $urandom_range(0, 3));
         endcase
         queue_random_samples(62);
      end

      wait_until_drained();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
